>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// Check that expr never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: label");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and codes of the indexed array list.
// ----------------------------------------------------------------------------
`default_nettype none

package ial_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FN_APPEND = 3'd0,
    FN_POP    = 3'd1,
    FN_INSERT = 3'd2,
    FN_ERASE  = 3'd3,
    FN_READ   = 3'd4,
    FN_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Command broadcast to every cell for one operation.
  typedef struct packed {
    logic ins;  // open a hole at pos, shift the tail up, load the word
    logic del;  // close the entry at pos, shift the tail down
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/ial_cell.sv
// ----------------------------------------------------------------------------
// ial_cell
// One list slot: holds a word, takes its neighbor's word on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ial_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CW    = 5,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                clk_i,
  input  wire ial_pkg::cell_cmd_t  cmd_i,
  input  wire logic [CW-1:0]       pos_i,
  input  wire logic [CW-1:0]       count_i,
  input  wire logic [WIDTH-1:0]    word_i,
  input  wire logic [WIDTH-1:0]    left_i,
  input  wire logic [WIDTH-1:0]    right_i,
  output logic      [WIDTH-1:0]    slot_o
);

  localparam logic [CW-1:0] IdxC  = CW'(IDX);
  localparam logic [CW-1:0] IdxP1 = CW'(IDX + 1);

  logic [WIDTH-1:0] slot_q;
  logic [WIDTH-1:0] slot_d;

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.ins) begin
      if (IdxC == pos_i) begin
        slot_d = word_i;
      end else if ((IdxC > pos_i) && (IdxC <= count_i)) begin
        slot_d = left_i;
      end
    end else if (cmd_i.del) begin
      if ((IdxC >= pos_i) && (IdxP1 < count_i)) begin
        slot_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

>>> rtl/core/indexed_array_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_array_list_unit
// Fixed-capacity ordered word list with insert/erase by position.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)            tuser
//  s_axis   in   position[4:0], item_value     func[2:0]
//  m_axis   out  read_value, count_now[4:0]    status[1:0]
//
//  Each beat is decoded and applied in the cycle it is accepted: the row of
//  cells shifts every entry in parallel, and a new beat is accepted every
//  cycle while the result register drains.
//  The result register is the only stage; s_axis_tready drops only while a
//  result is held and m_axis_tready is low.
//  Reset clears the entry count and the result valid; slot contents stay
//  undefined until written and are never read before that.
//
`default_nettype none
`include "assert_macros.svh"

module indexed_array_list_unit #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // s_axis
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // position[4:0], item_value[36:5], zero pad
  input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
  // m_axis
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // read_value[31:0], count_now[36:32], zero pad
  output logic      [1:0]  m_axis_tuser    // status[1:0]
);

  // Count width holds DEPTH itself; compare width also covers the position field.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned XW = (CW > ial_pkg::PosW) ? CW : ial_pkg::PosW;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  // ---------------------------------------------------------------- input beat
  logic                         in_fire;
  ial_pkg::func_e               func;
  logic [ial_pkg::PosW-1:0]     position;
  logic [ial_pkg::ValW-1:0]     item_value;
  logic [WIDTH+ial_pkg::ValW-1:0] item_ext;
  logic [WIDTH-1:0]             word;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign func       = ial_pkg::func_e'(s_axis_tuser);
  assign position   = s_axis_tdata[4:0];
  assign item_value = s_axis_tdata[36:5];
  // Keep the low WIDTH bits of the input word, zero-filled when WIDTH is wider.
  assign item_ext   = {{WIDTH{1'b0}}, item_value};
  assign word       = item_ext[WIDTH-1:0];

  // ---------------------------------------------------------------- state
  logic [CW-1:0] count_q;
  logic [CW-1:0] count_d;
  logic          out_valid_q;
  logic          out_valid_d;
  logic [ial_pkg::ValW-1:0]    rd_q;
  logic [ial_pkg::ValW-1:0]    rd_d;
  logic [ial_pkg::CountW-1:0]  cnt_q;
  ial_pkg::status_e            st_q;
  ial_pkg::status_e            st_d;

  // ---------------------------------------------------------------- cell row
  logic [WIDTH-1:0] tap_w  [DEPTH+1:0];   // tap[0] and tap[DEPTH+1] are the row ends
  logic [WIDTH-1:0] slot_w [DEPTH-1:0];
  ial_pkg::cell_cmd_t cmd;
  logic [CW-1:0]      cell_pos;

  assign tap_w[0]       = '0;
  assign tap_w[DEPTH+1] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ial_cell #(
      .IDX   (i),
      .CW    (CW),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .word_i  (word),
      .left_i  (tap_w[i]),
      .right_i (tap_w[i+2]),
      .slot_o  (tap_w[i+1])
    );
    assign slot_w[i] = tap_w[i+1];
  end

  // ---------------------------------------------------------------- decode
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [AW-1:0] rd_idx;
  logic [WIDTH+ial_pkg::ValW-1:0] rd_ext;

  assign pos_x  = XW'(position);
  assign cnt_x  = XW'(count_q);
  assign rd_idx = pos_x[AW-1:0];
  assign rd_ext = {{ial_pkg::ValW{1'b0}}, slot_w[rd_idx]};

  always_comb begin
    count_d  = count_q;
    st_d     = ial_pkg::ST_OK;
    rd_d     = '0;
    cmd      = '0;
    cell_pos = pos_x[CW-1:0];
    unique case (func)
      ial_pkg::FN_APPEND: begin
        if (count_q == Full) begin
          st_d = ial_pkg::ST_FULL;
        end else begin
          // Append is an insert at the tail.
          cmd.ins  = 1'b1;
          cell_pos = count_q;
          count_d  = count_q + CW'(1);
        end
      end
      ial_pkg::FN_POP: begin
        if (count_q == '0) begin
          st_d = ial_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      ial_pkg::FN_INSERT: begin
        if (pos_x > cnt_x) begin
          st_d = ial_pkg::ST_RANGE;
        end else if (count_q == Full) begin
          st_d = ial_pkg::ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      ial_pkg::FN_ERASE: begin
        if (pos_x >= cnt_x) begin
          st_d = ial_pkg::ST_RANGE;
        end else begin
          cmd.del = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      ial_pkg::FN_READ: begin
        if (pos_x >= cnt_x) begin
          st_d = ial_pkg::ST_RANGE;
        end else begin
          rd_d = rd_ext[ial_pkg::ValW-1:0];
        end
      end
      ial_pkg::FN_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // Unused codes: no change, status ok.
      end
    endcase
    // Apply nothing unless the beat is actually taken.
    if (!in_fire) begin
      cmd     = '0;
      count_d = count_q;
    end
  end

  // ---------------------------------------------------------------- handshake
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on every accepted beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q  <= rd_d;
      cnt_q <= ial_pkg::CountW'(count_d);
      st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, cnt_q, rd_q};
  assign m_axis_tuser  = st_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_NEVER(a_count_in_range, clk_i, rst_ni, count_q > Full)
  `ASSERT_CLK(a_fire_gives_result, clk_i, rst_ni, in_fire |=> m_axis_tvalid)
  `ASSERT_CLK(a_count_only_on_beat, clk_i, rst_ni, !in_fire |=> $stable(count_q))
  `ASSERT_CLK(a_full_append_holds, clk_i, rst_ni, (in_fire && func == ial_pkg::FN_APPEND && count_q == Full) |=> (st_q == ial_pkg::ST_FULL && $stable(count_q)))

endmodule

`default_nettype wire

>>> tb/sv/tb_indexed_array_list_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_array_list_unit
// Self-checking bench for the fixed-capacity indexed word list.
// Drives list operations on s_axis, tracks the list contents in a local
// shadow copy and checks every m_axis beat, field by field, against it or a typed-in result.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_unit;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned CLK_HALF = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned PHASE_OPS = 350;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Function codes the block treats as no-ops.
  localparam logic [ial_pkg::FuncW-1:0] FN_SPARE6 = 3'd6;
  localparam logic [ial_pkg::FuncW-1:0] FN_SPARE7 = 3'd7;

  typedef struct packed {
    logic [ial_pkg::ValW-1:0]   read_value;
    logic [ial_pkg::CountW-1:0] count_now;
    ial_pkg::status_e           status;
  } list_result_t;

  typedef struct {
    logic [ial_pkg::FuncW-1:0] fn;
    logic [ial_pkg::PosW-1:0]  pos;
    logic [ial_pkg::ValW-1:0]  val;
    int                        reps;
    bit                        typed;   // use the typed-in result instead of the shadow model
    list_result_t              want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // position[4:0], item_value[36:5], zero pad
  logic [2:0]  s_axis_tuser = '0;   // func[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // read_value[31:0], count_now[36:32], zero pad
  logic [1:0]  m_axis_tuser;        // status[1:0]

  // Shadow copy of the list.
  logic [ial_pkg::ValW-1:0] list_slots [LIST_DEPTH];
  int unsigned              list_count = 0;

  list_result_t pending_results [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int rx_hold_left = 0;
  int n_ops_sent = 0;
  int n_beats_checked = 0;
  int n_errors = 0;
  int status_hits [4] = '{0, 0, 0, 0};

  stim_row_t dir_rows [27];

  indexed_array_list_unit #(
    .DEPTH(LIST_DEPTH),
    .WIDTH(ial_pkg::ValW)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever begin
      #(CLK_HALF) clk_i = ~clk_i;
    end
  end

  // Apply one operation to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_op(input logic [ial_pkg::FuncW-1:0] fn,
                                                 input logic [ial_pkg::PosW-1:0] pos,
                                                 input logic [ial_pkg::ValW-1:0] val);
    list_result_t r;
    r.read_value = '0;
    r.status = ial_pkg::ST_OK;
    case (fn)
      ial_pkg::FN_APPEND: begin
        if (list_count >= LIST_DEPTH) begin
          r.status = ial_pkg::ST_FULL;
        end else begin
          list_slots[list_count] = val;
          list_count++;
        end
      end
      ial_pkg::FN_POP: begin
        if (list_count == 0) r.status = ial_pkg::ST_EMPTY;
        else list_count--;
      end
      ial_pkg::FN_INSERT: begin
        if (pos > list_count) begin
          r.status = ial_pkg::ST_RANGE;
        end else if (list_count >= LIST_DEPTH) begin
          r.status = ial_pkg::ST_FULL;
        end else begin
          // Shift the tail up by one, then drop the word into the hole.
          for (int i = list_count; i > pos; i--) list_slots[i] = list_slots[i - 1];
          list_slots[pos] = val;
          list_count++;
        end
      end
      ial_pkg::FN_ERASE: begin
        if (pos >= list_count) begin
          r.status = ial_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_count; i++) list_slots[i] = list_slots[i + 1];
          list_count--;
        end
      end
      ial_pkg::FN_READ: begin
        if (pos >= list_count) r.status = ial_pkg::ST_RANGE;
        else r.read_value = list_slots[pos];
      end
      ial_pkg::FN_CLEAR: list_count = 0;
      default: ;
    endcase
    r.count_now = ial_pkg::CountW'(list_count);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [ial_pkg::ValW-1:0] got,
                                 input logic [ial_pkg::ValW-1:0] want);
    n_errors++;
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // Offer one beat, wait for the handshake, then queue the result it owes.
  task automatic send_op(input logic [ial_pkg::FuncW-1:0] fn,
                         input logic [ial_pkg::PosW-1:0] pos,
                         input logic [ial_pkg::ValW-1:0] val, input bit typed,
                         input list_result_t want);
    list_result_t shadow;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {3'b000, val, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    shadow = apply_list_op(fn, pos, val);
    pending_results.insert(pending_results.size(), typed ? want : shadow);
    n_ops_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ial_pkg::ValW-1:0] pick_word();
    case ($urandom_range(19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random operations in runs: fill runs push the list toward full, drain
  // runs pull it toward empty, mixed runs do a bit of everything.
  task automatic run_random_ops(input int n_ops);
    int run_kind;
    int run_left;
    int pick;
    logic [ial_pkg::FuncW-1:0] fn;
    logic [ial_pkg::PosW-1:0] pos;
    run_kind = 2;
    run_left = 0;
    for (int k = 0; k < n_ops; k++) begin
      if (run_left == 0) begin
        run_kind = $urandom_range(2);
        run_left = $urandom_range(30, 8);
      end
      run_left--;
      pick = $urandom_range(99);
      if (run_kind == 0) begin
        if (pick < 40) fn = ial_pkg::FN_APPEND;
        else if (pick < 75) fn = ial_pkg::FN_INSERT;
        else if (pick < 90) fn = ial_pkg::FN_READ;
        else if (pick < 95) fn = ial_pkg::FN_ERASE;
        else fn = ial_pkg::FN_POP;
      end else if (run_kind == 1) begin
        if (pick < 35) fn = ial_pkg::FN_ERASE;
        else if (pick < 65) fn = ial_pkg::FN_POP;
        else if (pick < 85) fn = ial_pkg::FN_READ;
        else if (pick < 95) fn = ial_pkg::FN_APPEND;
        else fn = ial_pkg::FN_INSERT;
      end else begin
        if (pick < 18) fn = ial_pkg::FN_APPEND;
        else if (pick < 36) fn = ial_pkg::FN_INSERT;
        else if (pick < 52) fn = ial_pkg::FN_ERASE;
        else if (pick < 64) fn = ial_pkg::FN_POP;
        else if (pick < 90) fn = ial_pkg::FN_READ;
        else if (pick < 94) fn = ial_pkg::FN_CLEAR;
        else if (pick < 97) fn = FN_SPARE6;
        else fn = FN_SPARE7;
      end
      // Mostly legal positions; now and then anything the field can hold.
      if ($urandom_range(99) < 10) pos = ial_pkg::PosW'($urandom_range(31));
      else if (fn == ial_pkg::FN_INSERT) pos = ial_pkg::PosW'($urandom_range(list_count));
      else if (list_count == 0) pos = '0;
      else pos = ial_pkg::PosW'($urandom_range(list_count - 1));
      send_op(fn, pos, pick_word(), 1'b0, '0);
    end
  endtask

  task automatic check_beat();
    list_result_t want;
    n_beats_checked++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result beat", m_axis_tdata[31:0], '0);
    end else begin
      want = pending_results.pop_front();
      if (m_axis_tdata[31:0] !== want.read_value)
        report_mismatch("read_value", m_axis_tdata[31:0], want.read_value);
      if (m_axis_tdata[36:32] !== want.count_now)
        report_mismatch("count_now", ial_pkg::ValW'(m_axis_tdata[36:32]),
                        ial_pkg::ValW'(want.count_now));
      if (m_axis_tuser !== want.status)
        report_mismatch("status", ial_pkg::ValW'(m_axis_tuser), ial_pkg::ValW'(want.status));
      status_hits[want.status]++;
    end
  endtask

  // Sink side: random stalls, or a forced hold-off while the counter runs.
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_beat();
    end
  end

  initial begin
    #(4_000_000);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_rows = '{
      // Empty list straight after reset.
      '{ial_pkg::FN_POP, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_EMPTY}},
      '{ial_pkg::FN_READ, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_RANGE}},
      '{ial_pkg::FN_ERASE, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_RANGE}},
      '{ial_pkg::FN_INSERT, 5'd1, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_RANGE}},
      '{ial_pkg::FN_APPEND, 5'd0, 32'h8000_0000, 1, 1'b1, '{32'h0, 5'd1, ial_pkg::ST_OK}},
      '{ial_pkg::FN_APPEND, 5'd0, 32'h7FFF_FFFF, 1, 1'b1, '{32'h0, 5'd2, ial_pkg::ST_OK}},
      '{ial_pkg::FN_INSERT, 5'd0, 32'hFFFF_FFFF, 1, 1'b0, '0},
      // Insert right at the end acts as an append.
      '{ial_pkg::FN_INSERT, 5'd3, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_READ, 5'd0, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_READ, 5'd3, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_ERASE, 5'd1, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_READ, 5'd16, 32'h0, 1, 1'b1, '{32'h0, 5'd3, ial_pkg::ST_RANGE}},
      '{ial_pkg::FN_READ, 5'd31, 32'h0, 1, 1'b1, '{32'h0, 5'd3, ial_pkg::ST_RANGE}},
      '{FN_SPARE6, 5'd31, 32'hFFFF_FFFF, 1, 1'b0, '0},
      '{FN_SPARE7, 5'd0, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_CLEAR, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_OK}},
      // Fill to capacity, then hit every full-list case.
      '{ial_pkg::FN_APPEND, 5'd0, 32'h0000_1000, 16, 1'b0, '0},
      '{ial_pkg::FN_APPEND, 5'd0, 32'h1234_5678, 1, 1'b1, '{32'h0, 5'd16, ial_pkg::ST_FULL}},
      '{ial_pkg::FN_INSERT, 5'd16, 32'h1234_5678, 1, 1'b1, '{32'h0, 5'd16, ial_pkg::ST_FULL}},
      '{ial_pkg::FN_INSERT, 5'd17, 32'h1234_5678, 1, 1'b1, '{32'h0, 5'd16, ial_pkg::ST_RANGE}},
      '{ial_pkg::FN_INSERT, 5'd0, 32'h1234_5678, 1, 1'b1, '{32'h0, 5'd16, ial_pkg::ST_FULL}},
      '{ial_pkg::FN_READ, 5'd15, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_ERASE, 5'd0, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_POP, 5'd0, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_ERASE, 5'd13, 32'h0, 1, 1'b0, '0},
      '{ial_pkg::FN_CLEAR, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_OK}},
      '{ial_pkg::FN_POP, 5'd0, 32'h0, 1, 1'b1, '{32'h0, 5'd0, ial_pkg::ST_EMPTY}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        send_op(dir_rows[r].fn, dir_rows[r].pos, dir_rows[r].val + k,
                dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Back-to-back traffic on both sides.
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_random_ops(PHASE_OPS);

    // Hold the sink off for a long stretch while beats keep coming.
    rx_hold_left <= HOLD_OFF_CYCLES;
    run_random_ops(12);

    src_idle_pct = 52;
    sink_stall_pct = 0;
    run_random_ops(PHASE_OPS);

    // Pause the source until every result is back.
    drain_results();
    src_idle_pct = 0;
    sink_stall_pct = 52;
    run_random_ops(PHASE_OPS);

    src_idle_pct = 29;
    sink_stall_pct = 29;
    run_random_ops(PHASE_OPS);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran %0d list operations, checked %0d result beats", n_ops_sent,
             n_beats_checked);
    $display("status mix ok/range/empty/full: %0d/%0d/%0d/%0d",
             status_hits[ial_pkg::ST_OK], status_hits[ial_pkg::ST_RANGE],
             status_hits[ial_pkg::ST_EMPTY], status_hits[ial_pkg::ST_FULL]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ial_pkg.sv
rtl/core/ial_cell.sv
rtl/core/indexed_array_list_unit.sv
tb/sv/tb_indexed_array_list_unit.sv
